>>> hdl/msls_pkg.sv
// Package with the constants, codes and types of the multi sorted list store.
package msls_pkg;
   localparam int NUM_LISTS = 16;
   localparam int ENTRIES_PER_LIST = 16;
   localparam int ID_SPACE = 16;
   localparam int LIST_W = $clog2(NUM_LISTS);
   localparam int SLOT_W = $clog2(ENTRIES_PER_LIST);
   localparam int CNT_W = $clog2(ENTRIES_PER_LIST + 1);
   localparam int ADDR_W = LIST_W + SLOT_W;
   localparam int DEPTH = NUM_LISTS * ENTRIES_PER_LIST;
   localparam int ID_LIMIT = (NUM_LISTS < ID_SPACE) ? NUM_LISTS : ID_SPACE;

   localparam logic [2:0] MODE_CREATE = 3'd0;
   localparam logic [2:0] MODE_SHOW = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_REMOVE = 3'd3;
   localparam logic [2:0] MODE_DELETE = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_LIST = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_NO_FREE = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] list_id;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] out_list_id;
      logic signed [15:0] out_value;
      logic value_valid;
      logic last;
   } rsp_type;
endpackage

>>> hdl/msls_if.sv
// Valid and ready channel interfaces for the command and result items.
interface msls_req_if import msls_pkg::*; ();
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface msls_rsp_if import msls_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/msls_ram.sv
// Generic single port RAM with a registered read.
module msls_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> hdl/multi_sorted_list_store_unit.sv
// Top level of the multi sorted list store.
// Create, delete, empty show and error commands found at acceptance: result from S_RESP.
// Show reads one entry per cycle from the entry RAM while the result port does not stall.
// Insert and remove walk the list and then shift entries through the single RAM port,
// each entry with a read and then a write.
// One command at a time; synchronous reset clears all lists, no RAM clearing.
module multi_sorted_list_store_unit import msls_pkg::*; (
   input logic     clock,
   input logic     reset,
   msls_req_if.sink   req,
   msls_rsp_if.source rsp
);
   state_type state_ff, state_in;
   logic [NUM_LISTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0] count_ff [NUM_LISTS];
   logic [CNT_W-1:0] count_in [NUM_LISTS];
   req_type cmd_ff, cmd_in;
   logic [LIST_W-1:0] lid_ff, lid_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic rd_pend_ff, rd_pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic we;
   logic [SLOT_W-1:0] slot;
   logic [LIST_W-1:0] ram_lid;
   logic [ADDR_W-1:0] addr;
   logic [15:0] wdata, rdata;
   logic signed [15:0] rval;
   logic [LIST_W-1:0] free_id;
   logic free_found;
   logic [LIST_W-1:0] req_lid;
   logic req_exists;

   assign rval = rdata;
   assign addr = {ram_lid, slot};

   msls_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   always_comb begin
      free_found = 1'b0;
      free_id = '0;
      for (int i = ID_LIMIT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_id = LIST_W'(i);
         end
      end
   end

   assign req_lid = LIST_W'(req.payload.list_id);
   assign req_exists = (32'(req.payload.list_id) < NUM_LISTS) && used_ff[req_lid];
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      count_in = count_ff;
      cmd_in = cmd_ff;
      lid_in = lid_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      rd_pend_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in = rsp_ff;
      we = 1'b0;
      ram_lid = lid_ff;
      slot = idx_ff[SLOT_W-1:0];
      wdata = cmd_ff.value;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.payload;
               lid_in = req_lid;
               n_in = count_ff[req_lid];
               idx_in = '0;
               rsp_in = '{ST_OK, req.payload.list_id, 16'sd0, 1'b0, 1'b1};
               if (req.payload.mode == MODE_CREATE) begin
                  if (free_found) begin
                     used_in[free_id] = 1'b1;
                     count_in[free_id] = '0;
                     rsp_in.out_list_id = 4'(free_id);
                  end else begin
                     rsp_in.status = ST_NO_FREE;
                     rsp_in.out_list_id = '0;
                  end
                  state_in = S_RESP;
               end else if (req.payload.mode > MODE_DELETE) begin
                  state_in = S_IDLE;
               end else if (!req_exists) begin
                  rsp_in.status = ST_NO_LIST;
                  state_in = S_RESP;
               end else if (req.payload.mode == MODE_DELETE) begin
                  used_in[req_lid] = 1'b0;
                  count_in[req_lid] = '0;
                  state_in = S_RESP;
               end else if (req.payload.mode == MODE_INSERT &&
                            32'(count_ff[req_lid]) >= ENTRIES_PER_LIST) begin
                  rsp_in.status = ST_FULL;
                  state_in = S_RESP;
               end else if (count_ff[req_lid] == '0) begin
                  if (req.payload.mode == MODE_REMOVE) begin
                     rsp_in.status = ST_NOT_FOUND;
                     state_in = S_RESP;
                  end else if (req.payload.mode == MODE_SHOW) begin
                     state_in = S_RESP;
                  end else begin
                     pos_in = '0;
                     state_in = S_SHIFT;
                  end
               end else begin
                  ram_lid = req_lid;
                  slot = '0;
                  rd_pend_in = 1'b1;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // Address idx_ff was read in the previous cycle.
            if (cmd_ff.mode == MODE_SHOW) begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{ST_OK, cmd_ff.list_id, rval, 1'b1, idx_ff + 1'b1 == n_ff};
                  if (idx_ff + 1'b1 == n_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                     slot = idx_in[SLOT_W-1:0];
                  end
               end
            end else if (cmd_ff.mode == MODE_INSERT) begin
               if (rval > cmd_ff.value) begin
                  pos_in = idx_ff;
                  idx_in = n_ff;
                  state_in = S_SHIFT;
               end else if (idx_ff + 1'b1 == n_ff) begin
                  pos_in = n_ff;
                  idx_in = n_ff;
                  state_in = S_SHIFT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  slot = idx_in[SLOT_W-1:0];
               end
            end else begin
               if (rval == cmd_ff.value) begin
                  idx_in = idx_ff + 1'b1;
                  slot = idx_in[SLOT_W-1:0];
                  pos_in = idx_ff;
                  rd_pend_in = 1'b1;
                  state_in = S_SHIFT;
               end else if (rval > cmd_ff.value || idx_ff + 1'b1 == n_ff) begin
                  rsp_in.status = ST_NOT_FOUND;
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  slot = idx_in[SLOT_W-1:0];
               end
            end
         end
         S_SHIFT: begin
            if (cmd_ff.mode == MODE_INSERT) begin
               // Move entries up from the top, then place the value.
               if (idx_ff == pos_ff) begin
                  we = 1'b1;
                  slot = pos_ff[SLOT_W-1:0];
                  wdata = cmd_ff.value;
                  count_in[lid_ff] = n_ff + 1'b1;
                  state_in = S_RESP;
               end else if (!rd_pend_ff) begin
                  slot = SLOT_W'(idx_ff - 1'b1);
                  rd_pend_in = 1'b1;
               end else begin
                  we = 1'b1;
                  slot = idx_ff[SLOT_W-1:0];
                  wdata = rdata;
                  idx_in = idx_ff - 1'b1;
               end
            end else begin
               // Remove: read idx then write it to idx-1.
               if (idx_ff == n_ff) begin
                  count_in[lid_ff] = n_ff - 1'b1;
                  state_in = S_RESP;
               end else if (rd_pend_ff) begin
                  we = 1'b1;
                  slot = SLOT_W'(idx_ff - 1'b1);
                  wdata = rdata;
                  idx_in = idx_ff + 1'b1;
               end else begin
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         count_ff <= count_in;
      end
      cmd_ff <= cmd_in;
      lid_ff <= lid_in;
      n_ff <= n_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

>>> hdl/msls_checker.sv
// Port level checker for the multi sorted list store, bound to the top level.
module msls_checker import msls_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result item changed while stalled.");
   a_no_value_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> !rsp_payload.value_valid
      && rsp_payload.last)
      else $error("Error result carries a value or is not last.");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Command taken while a result is pending.");
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.value_valid |-> rsp_payload.out_value == 16'sd0)
      else $error("Result without a value has a nonzero value field.");
endmodule

bind multi_sorted_list_store_unit msls_checker u_msls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

>>> tb/msls_tb_scoreboard.sv
// Scoreboard class with the list store predictor and the queue of expected results.
`timescale 1ns / 100ps
class msls_scoreboard;
   bit list_live [16];
   logic signed [15:0] list_vals [16][$];
   msls_pkg::rsp_type expected_q [$];
   int error_count;

   function void clear_lists();
      for (int i = 0; i < 16; i++) begin
         list_live[i] = 0;
         list_vals[i].delete();
      end
      expected_q.delete();
      error_count = 0;
   endfunction

   function void push_rsp(logic [2:0] st, logic [3:0] id, logic signed [15:0] v,
                          logic vv, logic lst);
      msls_pkg::rsp_type r;
      r.status = st;
      r.out_list_id = id;
      r.out_value = v;
      r.value_valid = vv;
      r.last = lst;
      expected_q.push_back(r);
   endfunction

   function void note_command(msls_pkg::req_type c);
      int pos;
      bit found;
      if (c.mode == msls_pkg::MODE_CREATE) begin
         found = 0;
         for (int i = 0; i < msls_pkg::ID_LIMIT; i++) begin
            if (!found && !list_live[i]) begin
               found = 1;
               list_live[i] = 1;
               list_vals[i].delete();
               push_rsp(msls_pkg::ST_OK, 4'(i), 0, 0, 1);
            end
         end
         if (!found) push_rsp(msls_pkg::ST_NO_FREE, 0, 0, 0, 1);
         return;
      end
      if (c.mode > msls_pkg::MODE_DELETE) return;
      if (!list_live[c.list_id]) begin
         push_rsp(msls_pkg::ST_NO_LIST, c.list_id, 0, 0, 1);
         return;
      end
      case (c.mode)
         msls_pkg::MODE_SHOW: begin
            if (list_vals[c.list_id].size() == 0) begin
               push_rsp(msls_pkg::ST_OK, c.list_id, 0, 0, 1);
            end else begin
               foreach (list_vals[c.list_id][k])
                  push_rsp(msls_pkg::ST_OK, c.list_id, list_vals[c.list_id][k], 1,
                           k == list_vals[c.list_id].size() - 1);
            end
         end
         msls_pkg::MODE_INSERT: begin
            if (list_vals[c.list_id].size() >= msls_pkg::ENTRIES_PER_LIST) begin
               push_rsp(msls_pkg::ST_FULL, c.list_id, 0, 0, 1);
            end else begin
               pos = 0;
               while (pos < list_vals[c.list_id].size() &&
                      list_vals[c.list_id][pos] <= c.value) pos++;
               list_vals[c.list_id].insert(pos, c.value);
               push_rsp(msls_pkg::ST_OK, c.list_id, 0, 0, 1);
            end
         end
         msls_pkg::MODE_REMOVE: begin
            pos = 0;
            while (pos < list_vals[c.list_id].size() &&
                   list_vals[c.list_id][pos] < c.value) pos++;
            if (pos >= list_vals[c.list_id].size() || list_vals[c.list_id][pos] != c.value) begin
               push_rsp(msls_pkg::ST_NOT_FOUND, c.list_id, 0, 0, 1);
            end else begin
               list_vals[c.list_id].delete(pos);
               push_rsp(msls_pkg::ST_OK, c.list_id, 0, 0, 1);
            end
         end
         default: begin
            list_live[c.list_id] = 0;
            list_vals[c.list_id].delete();
            push_rsp(msls_pkg::ST_OK, c.list_id, 0, 0, 1);
         end
      endcase
   endfunction

   function void check_rsp(msls_pkg::rsp_type got);
      msls_pkg::rsp_type exp;
      if (expected_q.size() == 0) begin
         $error("unexpected result item %p", got);
         error_count++;
         return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
         $error("status expected %0d actual %0d", exp.status, got.status);
         error_count++;
      end
      if (got.out_list_id !== exp.out_list_id) begin
         $error("out_list_id expected %0d actual %0d", exp.out_list_id, got.out_list_id);
         error_count++;
      end
      if (got.out_value !== exp.out_value) begin
         $error("out_value expected %0d actual %0d", exp.out_value, got.out_value);
         error_count++;
      end
      if (got.value_valid !== exp.value_valid) begin
         $error("value_valid expected %0d actual %0d", exp.value_valid, got.value_valid);
         error_count++;
      end
      if (got.last !== exp.last) begin
         $error("last expected %0d actual %0d", exp.last, got.last);
         error_count++;
      end
   endfunction
endclass

>>> tb/multi_sorted_list_store_unit_tb.sv
// Testbench top for the multi sorted list store with directed and random stimulus, idling and stalls.
`timescale 1ns / 100ps
module multi_sorted_list_store_unit_tb;
   import msls_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   bit done = 0;
   msls_scoreboard list_board;

   msls_req_if req ();
   msls_rsp_if rsp ();

   multi_sorted_list_store_unit u_top (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) list_board.check_rsp(rsp.payload);
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000 && !done) begin
         $display("multi_sorted_list_store_unit_tb: FAIL");
         $finish;
      end
   end

   task automatic send_cmd(logic [2:0] m, logic [3:0] id, logic signed [15:0] v);
      req_type c;
      c.mode = m;
      c.list_id = id;
      c.value = v;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.payload <= c;
      do @(posedge clock); while (!req.ready);
      list_board.note_command(c);
   endtask

   task automatic drain_results();
      req.valid <= 0;
      while (list_board.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(3))
         0: return 16'($urandom_range(7) - 4);
         1: return 16'sh8000 + 16'($urandom_range(3));
         2: return 16'sh7fff - 16'($urandom_range(3));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_cmds(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 8) send_cmd(MODE_CREATE, 4'($urandom), 16'($urandom));
         else if (r < 20) send_cmd(MODE_SHOW, 4'($urandom_range(5)), 16'($urandom));
         else if (r < 60) send_cmd(MODE_INSERT, 4'($urandom_range(5)), pick_value());
         else if (r < 82) send_cmd(MODE_REMOVE, 4'($urandom_range(5)), pick_value());
         else if (r < 86) send_cmd(MODE_DELETE, 4'($urandom_range(5)), 16'($urandom));
         else if (r < 92) send_cmd(3'($urandom_range(7)), 4'($urandom), 16'($urandom));
         else send_cmd(3'(MODE_INSERT + $urandom_range(1)), 4'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      req.valid = 0;
      req.payload = '0;
      list_board = new();
      list_board.clear_lists();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed part: empty list, duplicates, extremes, full list, unknown list,
      // no free number, missing value and ignored modes.
      send_cmd(MODE_SHOW, 4'd0, 0);
      send_cmd(MODE_CREATE, 4'd15, 16'sh7fff);
      send_cmd(MODE_SHOW, 4'd0, 0);
      send_cmd(MODE_INSERT, 4'd0, 16'sh7fff);
      send_cmd(MODE_INSERT, 4'd0, 16'sh8000);
      send_cmd(MODE_INSERT, 4'd0, 16'sh0005);
      send_cmd(MODE_INSERT, 4'd0, 16'sh0005);
      send_cmd(MODE_REMOVE, 4'd0, 16'sh0006);
      send_cmd(MODE_REMOVE, 4'd0, 16'sh0005);
      send_cmd(MODE_SHOW, 4'd0, 0);
      send_cmd(3'd5, 4'd0, 0);
      send_cmd(3'd6, 4'd15, 16'shffff);
      send_cmd(3'd7, 4'd3, 0);
      send_cmd(MODE_INSERT, 4'd15, 1);
      for (int k = 0; k < 14; k++) send_cmd(MODE_INSERT, 4'd0, 16'($urandom));
      send_cmd(MODE_INSERT, 4'd0, 0);
      send_cmd(MODE_SHOW, 4'd0, 0);
      for (int k = 0; k < 16; k++) send_cmd(MODE_CREATE, 0, 0);
      send_cmd(MODE_DELETE, 4'd0, 0);
      send_cmd(MODE_REMOVE, 4'd0, 0);
      send_cmd(MODE_DELETE, 4'd15, 0);
      for (int k = 1; k < 15; k++) send_cmd(MODE_DELETE, 4'(k), 0);
      drain_results();
      random_cmds(67);
      send_idle_pct = 63;
      random_cmds(67);
      drain_results();
      send_idle_pct = 0;
      recv_stall_pct = 63;
      random_cmds(67);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      random_cmds(67);
      drain_results();
      done = 1;
      if (list_board.error_count == 0 && list_board.expected_q.size() == 0) begin
         $display("multi_sorted_list_store_unit_tb: PASS");
      end else begin
         $display("multi_sorted_list_store_unit_tb: FAIL");
      end
      $finish;
   end
endmodule
